// File: sv/heat_stencil_sweep_assert.svh
// Assertion macros shared by the heat stencil sweep RTL.
`ifndef HEAT_STENCIL_SWEEP_ASSERT_SVH
`define HEAT_STENCIL_SWEEP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define HSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define HSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define HSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: sv/hss_pkg.sv
// Shared constants and types for the heat stencil sweep.
package hss_pkg;

    // Temperatures are unsigned Q16.8.
    localparam int TEMP_BITS         = 24;
    localparam int MAX_WIDTH_DEFAULT = 256;
    localparam int MAX_HEIGHT        = 256;
    localparam int SIZE_BITS         = 9;
    localparam int COEF_BITS         = 16;
    localparam int POS_BITS          = 8;
    localparam int FRAC_BITS         = 16;

    // Laplacian term w + e - 2c needs two extra bits and a sign bit.
    localparam int LAP_BITS  = TEMP_BITS + 3;
    localparam int PROD_BITS = LAP_BITS + COEF_BITS + 1;

    localparam logic [TEMP_BITS-1:0] TEMP_MAX = '1;

    typedef logic [TEMP_BITS-1:0] temp_t;

    // Configuration as seen by the datapath, sizes already clamped.
    typedef struct packed {
        logic [SIZE_BITS-1:0] wd;
        logic [SIZE_BITS-1:0] ht;
        logic [COEF_BITS-1:0] coef_x;
        logic [COEF_BITS-1:0] coef_y;
        logic                 src_en;
        logic [POS_BITS-1:0]  src_row;
        logic [POS_BITS-1:0]  src_col;
        temp_t                src_val;
    } hss_cfg_t;

    // One five-point window plus the flags of the cell it belongs to.
    typedef struct packed {
        temp_t               north;
        temp_t               west;
        temp_t               centre;
        temp_t               east;
        temp_t               south;
        logic                border;
        logic                src;
        logic                last;
        logic [POS_BITS-1:0] row;
        logic [POS_BITS-1:0] col;
    } hss_win_t;

endpackage

// File: sv/hss_ram.sv
// Generic single-write, single-read RAM with registered read-first output.
module hss_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/hss_regs.sv
// Configuration register file with APB-style access and size clamping.
module hss_regs
    import hss_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output hss_cfg_t    cfg
);

    localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [2:0] REG_COEF_X      = 3'd2;
    localparam logic [2:0] REG_COEF_Y      = 3'd3;
    localparam logic [2:0] REG_SRC_ENABLE  = 3'd4;
    localparam logic [2:0] REG_SRC_ROW     = 3'd5;
    localparam logic [2:0] REG_SRC_COL     = 3'd6;
    localparam logic [2:0] REG_SRC_VALUE   = 3'd7;

    localparam logic [SIZE_BITS-1:0] SIZE_RESET  = SIZE_BITS'(256);
    localparam logic [SIZE_BITS-1:0] SIZE_MIN    = SIZE_BITS'(3);
    localparam temp_t                SRC_RESET   = TEMP_BITS'(102400);

    logic [SIZE_BITS-1:0] grid_width_reg;
    logic [SIZE_BITS-1:0] grid_height_reg;
    logic [COEF_BITS-1:0] coef_x_reg;
    logic [COEF_BITS-1:0] coef_y_reg;
    logic                 src_en_reg;
    logic [POS_BITS-1:0]  src_row_reg;
    logic [POS_BITS-1:0]  src_col_reg;
    temp_t                src_val_reg;

    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // Register writes complete in the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= SIZE_RESET;
            grid_height_reg <= SIZE_RESET;
            coef_x_reg      <= '0;
            coef_y_reg      <= '0;
            src_en_reg      <= 1'b0;
            src_row_reg     <= '0;
            src_col_reg     <= '0;
            src_val_reg     <= SRC_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_GRID_WIDTH:  grid_width_reg  <= pwdata[SIZE_BITS-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= pwdata[SIZE_BITS-1:0];
                REG_COEF_X:      coef_x_reg      <= pwdata[COEF_BITS-1:0];
                REG_COEF_Y:      coef_y_reg      <= pwdata[COEF_BITS-1:0];
                REG_SRC_ENABLE:  src_en_reg      <= pwdata[0];
                REG_SRC_ROW:     src_row_reg     <= pwdata[POS_BITS-1:0];
                REG_SRC_COL:     src_col_reg     <= pwdata[POS_BITS-1:0];
                REG_SRC_VALUE:   src_val_reg     <= pwdata[TEMP_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // Read data mux.
    always_comb
    begin
        unique case (reg_idx)
            REG_GRID_WIDTH:  prdata = 32'(grid_width_reg);
            REG_GRID_HEIGHT: prdata = 32'(grid_height_reg);
            REG_COEF_X:      prdata = 32'(coef_x_reg);
            REG_COEF_Y:      prdata = 32'(coef_y_reg);
            REG_SRC_ENABLE:  prdata = 32'(src_en_reg);
            REG_SRC_ROW:     prdata = 32'(src_row_reg);
            REG_SRC_COL:     prdata = 32'(src_col_reg);
            REG_SRC_VALUE:   prdata = 32'(src_val_reg);
            default:         prdata = '0;
        endcase
    end

    // Grid sizes are clamped to the range the line buffers support.
    always_comb
    begin
        priority if (grid_width_reg < SIZE_MIN)
        begin
            cfg.wd = SIZE_MIN;
        end
        else if (32'(grid_width_reg) > MAX_WIDTH)
        begin
            cfg.wd = SIZE_BITS'(MAX_WIDTH);
        end
        else
        begin
            cfg.wd = grid_width_reg;
        end

        priority if (grid_height_reg < SIZE_MIN)
        begin
            cfg.ht = SIZE_MIN;
        end
        else if (32'(grid_height_reg) > MAX_HEIGHT)
        begin
            cfg.ht = SIZE_BITS'(MAX_HEIGHT);
        end
        else
        begin
            cfg.ht = grid_height_reg;
        end

        cfg.coef_x  = coef_x_reg;
        cfg.coef_y  = coef_y_reg;
        cfg.src_en  = src_en_reg;
        cfg.src_row = src_row_reg;
        cfg.src_col = src_col_reg;
        cfg.src_val = src_val_reg;
    end

endmodule

// File: sv/hss_window.sv
// Raster position counters, line buffers and the window stage.
module hss_window
    import hss_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    input  hss_cfg_t cfg,
    input  logic     cell_valid,
    output logic     cell_stall,
    input  temp_t    cell_temp,
    input  logic     pad,
    output logic     win_valid,
    input  logic     win_stall,
    output hss_win_t win
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);

    logic [COL_BITS-1:0]  col_reg, col_next;
    logic [SIZE_BITS-1:0] row_reg, row_next;
    logic                 s1_valid_reg, s1_valid_next;
    temp_t                west_reg;
    logic                 above_wr_reg;
    logic [COL_BITS-1:0]  above_addr_reg;

    temp_t               south_reg;
    logic                border_reg;
    logic                src_reg;
    logic                last_reg;
    logic [POS_BITS-1:0] row_out_reg;
    logic [POS_BITS-1:0] col_out_reg;

    logic                 accept;
    logic                 restart;
    logic [SIZE_BITS-1:0] r;
    logic [COL_BITS-1:0]  c;
    logic [COL_BITS-1:0]  c_inc;
    logic [COL_BITS-1:0]  east_addr;
    logic [SIZE_BITS-1:0] orow;
    logic [SIZE_BITS-1:0] ht_m1;
    logic                 emit;
    logic                 last_col;
    logic                 line_wr;
    logic                 win_fire;
    temp_t                v;
    temp_t                north_rd, centre_rd, east_rd;

    assign cell_stall = s1_valid_reg && win_stall;
    assign accept     = cell_valid && !cell_stall;
    assign win_fire   = s1_valid_reg && !win_stall;

    // Position of the incoming cell; a stale position restarts the frame.
    always_comb
    begin
        restart   = (32'(col_reg) >= 32'(cfg.wd)) || (row_reg > cfg.ht);
        r         = restart ? '0 : row_reg;
        c         = restart ? '0 : col_reg;
        c_inc     = c + 1'b1;
        east_addr = (32'(c) + 32'd1 >= MAX_WIDTH) ? '0 : c_inc;
        v         = pad ? '0 : cell_temp;
        orow      = r - 1'b1;
        ht_m1     = cfg.ht - 1'b1;
        emit      = (r != '0);
        last_col  = (32'(c) + 32'd1 >= 32'(cfg.wd));
        line_wr   = accept && (r < cfg.ht);
    end

    // Counter and stage-valid update.
    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        s1_valid_next = s1_valid_reg;
        if (win_fire)
        begin
            s1_valid_next = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = emit;
            if (last_col)
            begin
                col_next = '0;
                row_next = (r >= cfg.ht) ? '0 : r + 1'b1;
            end
            else
            begin
                col_next = c_inc;
                row_next = r;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            west_reg     <= '0;
            above_wr_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
            above_wr_reg <= line_wr;
            if (win_fire)
            begin
                west_reg <= centre_rd;
            end
        end
    end

    // Cell flags travel with the window word.
    always_ff @(posedge clk)
    begin
        if (line_wr)
        begin
            above_addr_reg <= c;
        end
        if (accept)
        begin
            south_reg   <= v;
            border_reg  <= (orow == '0) || (orow == ht_m1) || (c == '0) || last_col;
            src_reg     <= cfg.src_en && (orow == SIZE_BITS'(cfg.src_row))
                           && (32'(c) == 32'(cfg.src_col));
            last_reg    <= (orow == ht_m1) && last_col;
            row_out_reg <= orow[POS_BITS-1:0];
            col_out_reg <= POS_BITS'(c);
        end
    end

    // Middle line, read at the centre column.
    hss_ram #(
        .WIDTH (TEMP_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_mid_c (
        .clk     (clk),
        .wr_en   (line_wr),
        .wr_addr (c),
        .wr_data (v),
        .rd_en   (accept),
        .rd_addr (c),
        .rd_data (centre_rd)
    );

    // Copy of the middle line, read at the east column.
    hss_ram #(
        .WIDTH (TEMP_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_mid_e (
        .clk     (clk),
        .wr_en   (line_wr),
        .wr_addr (c),
        .wr_data (v),
        .rd_en   (accept),
        .rd_addr (east_addr),
        .rd_data (east_rd)
    );

    // Upper line takes the old middle value in the cycle after the read.
    hss_ram #(
        .WIDTH (TEMP_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_above (
        .clk     (clk),
        .wr_en   (above_wr_reg),
        .wr_addr (above_addr_reg),
        .wr_data (centre_rd),
        .rd_en   (accept),
        .rd_addr (c),
        .rd_data (north_rd)
    );

    // Window word toward the update pipeline.
    always_comb
    begin
        win_valid  = s1_valid_reg;
        win.north  = north_rd;
        win.west   = west_reg;
        win.centre = centre_rd;
        win.east   = east_rd;
        win.south  = south_reg;
        win.border = border_reg;
        win.src    = src_reg;
        win.last   = last_reg;
        win.row    = row_out_reg;
        win.col    = col_out_reg;
    end

endmodule

// File: sv/hss_update.sv
// Stencil arithmetic pipeline: Laplacians, coefficient products, rounding.
`include "heat_stencil_sweep_assert.svh"

module hss_update
    import hss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  hss_cfg_t            cfg,
    input  logic                win_valid,
    output logic                win_stall,
    input  hss_win_t            win,
    output logic                result_valid,
    input  logic                result_stall,
    output temp_t               new_temp,
    output logic [POS_BITS-1:0] out_row,
    output logic [POS_BITS-1:0] out_col,
    output logic                frame_last
);

    localparam int SUM_BITS   = PROD_BITS + 1;
    localparam int DELTA_BITS = SUM_BITS - FRAC_BITS;
    localparam int RES_BITS   = DELTA_BITS + 1;
    localparam logic signed [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(2 ** (FRAC_BITS - 1));

    typedef struct packed {
        temp_t               centre;
        logic                border;
        logic                src;
        logic                last;
        logic [POS_BITS-1:0] row;
        logic [POS_BITS-1:0] col;
    } side_t;

    logic                        a_valid_reg, b_valid_reg, out_valid_reg;
    side_t                       side_a_reg, side_b_reg;
    logic signed [LAP_BITS-1:0]  lx_reg, ly_reg;
    logic signed [PROD_BITS-1:0] px_reg, py_reg;
    temp_t                       new_temp_reg;
    logic [POS_BITS-1:0]         out_row_reg, out_col_reg;
    logic                        frame_last_reg;

    logic                         out_ready, b_ready, a_ready;
    logic                         a_load, b_load, out_load;
    side_t                        side_in;
    logic signed [LAP_BITS-1:0]   lx_next, ly_next;
    logic signed [PROD_BITS-1:0]  px_next, py_next;
    logic signed [SUM_BITS-1:0]   sum;
    logic signed [DELTA_BITS-1:0] delta;
    logic signed [RES_BITS-1:0]   res;
    temp_t                        sat;
    temp_t                        result;

    // Stage handshakes: a stage loads when it is empty or drains.
    assign out_ready = !out_valid_reg || !result_stall;
    assign b_ready   = !b_valid_reg || out_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign win_stall = !a_ready;
    assign a_load    = win_valid && a_ready;
    assign b_load    = a_valid_reg && b_ready;
    assign out_load  = b_valid_reg && out_ready;

    // Laplacian terms along each axis.
    always_comb
    begin
        side_in.centre = win.centre;
        side_in.border = win.border;
        side_in.src    = win.src;
        side_in.last   = win.last;
        side_in.row    = win.row;
        side_in.col    = win.col;
        lx_next = LAP_BITS'(win.west) + LAP_BITS'(win.east) - (LAP_BITS'(win.centre) << 1);
        ly_next = LAP_BITS'(win.north) + LAP_BITS'(win.south) - (LAP_BITS'(win.centre) << 1);
    end

    // One signed multiply per axis.
    always_comb
    begin
        px_next = lx_reg * $signed({1'b0, cfg.coef_x});
        py_next = ly_reg * $signed({1'b0, cfg.coef_y});
    end

    // Sum, round half up, add to the centre and saturate; source and border cells override it.
    always_comb
    begin
        sum   = SUM_BITS'(px_reg) + SUM_BITS'(py_reg) + ROUND_HALF;
        delta = sum[SUM_BITS-1:FRAC_BITS];
        res   = RES_BITS'(delta) + RES_BITS'({1'b0, side_b_reg.centre});
        priority if (res < 0)
        begin
            sat = '0;
        end
        else if (res > $signed(RES_BITS'({1'b0, TEMP_MAX})))
        begin
            sat = TEMP_MAX;
        end
        else
        begin
            sat = res[TEMP_BITS-1:0];
        end

        priority if (side_b_reg.src)
        begin
            result = cfg.src_val;
        end
        else if (side_b_reg.border)
        begin
            result = side_b_reg.centre;
        end
        else
        begin
            result = sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= win_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    // Payload registers of the three stages.
    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            side_a_reg <= side_in;
            lx_reg     <= lx_next;
            ly_reg     <= ly_next;
        end
        if (b_load)
        begin
            side_b_reg <= side_a_reg;
            px_reg     <= px_next;
            py_reg     <= py_next;
        end
        if (out_load)
        begin
            new_temp_reg   <= result;
            out_row_reg    <= side_b_reg.row;
            out_col_reg    <= side_b_reg.col;
            frame_last_reg <= side_b_reg.last;
        end
    end

    assign result_valid = out_valid_reg;
    assign new_temp     = new_temp_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign frame_last   = frame_last_reg;

    // The last cell of a frame always sits in the last column and is flagged as border.
    `HSS_ASSERT_NOW(a_last_is_border, clk, rst_n, b_valid_reg && side_b_reg.last, side_b_reg.border, "last cell not flagged as border")
    // A forced source cell shows the source temperature.
    `HSS_ASSERT_NEXT(a_src_forced, clk, rst_n, out_load && side_b_reg.src, new_temp_reg == $past(cfg.src_val), "source cell not forced")
    // Border cells pass through unchanged.
    `HSS_ASSERT_NEXT(a_border_pass, clk, rst_n, out_load && side_b_reg.border && !side_b_reg.src, new_temp_reg == $past(side_b_reg.centre), "border cell changed")
    // Zero Laplacians leave an interior cell unchanged after rounding.
    `HSS_ASSERT_NEXT(a_flat_keeps, clk, rst_n, out_load && px_reg == '0 && py_reg == '0 && !side_b_reg.src, new_temp_reg == $past(side_b_reg.centre), "flat cell changed")

endmodule

// File: sv/heat_stencil_sweep.sv
// Top level of the heat stencil sweep: registers, window and update pipeline.
//
// One explicit FTCS sweep of the 2D heat equation over a grid streamed in raster
// order, one cell word per clock sustained while cell_stall is low. Each accepted
// cell reads three line buffer RAMs and writes them once, which is what bounds the
// rate at one cell per cycle. Results come out one row behind the input: the cells
// of row 0 produce no word, and after the last grid row the caller sends one row
// of pad words (grid_width of them) to drain the final row. An emitted result
// passes the window stage, stages A and B and the result register in turn. Border
// cells pass through unchanged, interior cells get c + kx*(w-2c+e) + ky*(n-2c+s)
// rounded half up and saturated to Q16.8, and the optional source cell is forced
// last. Line buffers need no clearing after reset. Configuration must be written
// only while no word is in flight; the block itself does not enforce this.
module heat_stencil_sweep
    import hss_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                cell_valid,
    output logic                cell_stall,
    input  temp_t               cell_temp,
    input  logic                pad,
    output logic                result_valid,
    input  logic                result_stall,
    output temp_t               new_temp,
    output logic [POS_BITS-1:0] out_row,
    output logic [POS_BITS-1:0] out_col,
    output logic                frame_last
);

    hss_cfg_t cfg;
    logic     win_valid;
    logic     win_stall;
    hss_win_t win;

    // Configuration registers.
    hss_regs #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Position tracking and line buffers.
    hss_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cell_valid (cell_valid),
        .cell_stall (cell_stall),
        .cell_temp  (cell_temp),
        .pad        (pad),
        .win_valid  (win_valid),
        .win_stall  (win_stall),
        .win        (win)
    );

    // Arithmetic and result register.
    hss_update u_update (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .win_valid    (win_valid),
        .win_stall    (win_stall),
        .win          (win),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .new_temp     (new_temp),
        .out_row      (out_row),
        .out_col      (out_col),
        .frame_last   (frame_last)
    );

endmodule
